// File: sv/itoa_pkg.sv
// Shared types, constants and register codes for the decimal text converter.
`timescale 1ns / 1ps

package itoa_pkg;

  // Largest text, padding included, that padding may fill up to.
  localparam int BUF_CHARS = 11;

  // Widths of the binary value, the BCD digit store and the character counters.
  localparam int VALUE_W  = 32;
  localparam int DIGITS   = 10;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int CHAR_W   = 8;
  localparam int LEN_W    = 5;
  localparam int CNT_W    = 4;
  localparam int STEP_W   = 5;

  // ASCII codes used in the text.
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // Register index codes, taken from paddr[2].
  localparam logic REG_PAD    = 1'b0;
  localparam logic REG_TARGET = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_MEASURE,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic measure;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_last;
    logic out_free;
    logic emit_last;
  } status_t;

endpackage

// File: sv/itoa_ctrl.sv
// Controller state machine that sequences load, conversion, measuring and emission.
`timescale 1ns / 1ps

module itoa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               value_valid,
  output logic               value_stall,
  input  itoa_pkg::status_t  status,
  output itoa_pkg::cmd_t     cmd
);

  itoa_pkg::state_t state;
  itoa_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itoa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      itoa_pkg::ST_IDLE: begin
        if (value_valid) state_next = itoa_pkg::ST_CONVERT;
      end
      itoa_pkg::ST_CONVERT: begin
        if (status.conv_last) state_next = itoa_pkg::ST_MEASURE;
      end
      itoa_pkg::ST_MEASURE: begin
        state_next = itoa_pkg::ST_EMIT;
      end
      itoa_pkg::ST_EMIT: begin
        if (status.out_free && status.emit_last) state_next = itoa_pkg::ST_IDLE;
      end
      default: begin
        state_next = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs: the datapath only moves a character when the output register is free.
  always_comb begin
    cmd         = '0;
    value_stall = 1'b1;
    case (state)
      itoa_pkg::ST_IDLE: begin
        value_stall = 1'b0;
        cmd.load    = value_valid;
      end
      itoa_pkg::ST_CONVERT: begin
        cmd.step = 1'b1;
      end
      itoa_pkg::ST_MEASURE: begin
        cmd.measure = 1'b1;
      end
      itoa_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: sv/itoa_dp.sv
// Datapath: shift-add-3 conversion, text length and padding, and the character output register.
`timescale 1ns / 1ps

module itoa_dp #(
  parameter int BUF_CHARS = itoa_pkg::BUF_CHARS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [itoa_pkg::VALUE_W-1:0]         value,
  input  logic                                 command,
  input  logic                                 pad_with_spaces,
  input  logic [itoa_pkg::LEN_W-1:0]           target_length,
  input  itoa_pkg::cmd_t                       cmd,
  output itoa_pkg::status_t                    status,
  output logic                                 character_valid,
  input  logic                                 character_stall,
  output logic [itoa_pkg::CHAR_W-1:0]          character,
  output logic                                 last
);

  logic [itoa_pkg::VALUE_W-1:0]           bin;
  logic [itoa_pkg::DIGITS-1:0][3:0]       bcd;
  logic [itoa_pkg::DIGITS-1:0][3:0]       bcd_adj;
  logic [itoa_pkg::STEP_W-1:0]            step_cnt;
  logic                                   neg;
  logic [itoa_pkg::LEN_W-1:0]             pad_len;
  logic [itoa_pkg::LEN_W-1:0]             total;
  logic [itoa_pkg::LEN_W-1:0]             pos;
  logic                                   load_neg;
  logic [itoa_pkg::VALUE_W-1:0]           load_mag;
  logic [itoa_pkg::CNT_W-1:0]             digit_count;
  logic [itoa_pkg::LEN_W-1:0]             text_len;
  logic [itoa_pkg::LEN_W-1:0]             pad_calc;
  logic [itoa_pkg::LEN_W-1:0]             digit_idx;
  logic [3:0]                             digit;
  logic [itoa_pkg::CHAR_W-1:0]            char_sel;
  logic                                   out_free;
  logic                                   fire;

  // Sign and magnitude of the incoming value; the most negative value negates to itself.
  assign load_neg = command & value[itoa_pkg::VALUE_W-1];
  assign load_mag = load_neg ? (~value + 1'b1) : value;

  // Add 3 to every BCD digit of 5 or more before the next shift.
  always_comb begin
    for (int i = 0; i < itoa_pkg::DIGITS; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? (bcd[i] + 4'd3) : bcd[i];
    end
  end

  // Number of significant digits, at least one.
  always_comb begin
    digit_count = 4'd1;
    for (int i = 1; i < itoa_pkg::DIGITS; i++) begin
      if (bcd[i] != 4'd0) digit_count = itoa_pkg::CNT_W'(i + 1);
    end
  end

  // Text length with sign, and the pad count when the target fits the buffer.
  assign text_len = {1'b0, digit_count} + {{(itoa_pkg::LEN_W-1){1'b0}}, neg};
  assign pad_calc = (target_length > text_len &&
                     target_length <= itoa_pkg::LEN_W'(BUF_CHARS))
                    ? (target_length - text_len) : '0;

  // Conversion registers: load, one shift-add-3 step a cycle, then measure.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin      <= load_mag;
      bcd      <= '0;
      neg      <= load_neg;
      step_cnt <= '0;
    end else if (cmd.step) begin
      bcd      <= itoa_pkg::BCD_W'({bcd_adj, bin[itoa_pkg::VALUE_W-1]});
      bin      <= {bin[itoa_pkg::VALUE_W-2:0], 1'b0};
      step_cnt <= step_cnt + 1'b1;
    end
  end

  // Padding and total length, fixed for the whole emission.
  always_ff @(posedge clk) begin
    if (cmd.measure) begin
      pad_len <= pad_calc;
      total   <= pad_calc + text_len;
      pos     <= '0;
    end else if (fire) begin
      pos     <= pos + 1'b1;
    end
  end

  // Character at the current position: pad, then sign, then digits from the top.
  assign digit_idx = total - pos - 1'b1;
  assign digit     = (digit_idx < itoa_pkg::LEN_W'(itoa_pkg::DIGITS))
                     ? bcd[digit_idx[itoa_pkg::CNT_W-1:0]] : 4'd0;

  always_comb begin
    if (pos < pad_len) begin
      char_sel = pad_with_spaces ? itoa_pkg::CH_SPACE : itoa_pkg::CH_ZERO;
    end else if (neg && pos == pad_len) begin
      char_sel = itoa_pkg::CH_MINUS;
    end else begin
      char_sel = itoa_pkg::CH_ZERO + {4'b0, digit};
    end
  end

  // Output register takes a new character when empty or when its transfer completes.
  assign out_free = ~character_valid | ~character_stall;
  assign fire     = cmd.emit & out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      character_valid <= 1'b0;
    end else if (fire) begin
      character_valid <= 1'b1;
    end else if (!character_stall) begin
      character_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      character <= char_sel;
      last      <= (pos == total - 1'b1);
    end
  end

  // Status back to the controller.
  assign status.conv_last = (step_cnt == itoa_pkg::STEP_W'(itoa_pkg::VALUE_W - 1));
  assign status.out_free  = out_free;
  assign status.emit_last = (pos == total - 1'b1);

endmodule

// File: sv/integer_to_padded_decimal_text.sv
// Top level of the decimal text converter: register port, controller and datapath.
`timescale 1ns / 1ps
//
// Converts one 32-bit value a transfer into decimal ASCII, one character per
// output transfer, most significant first, with last set on the final one.
// Input channel: value, command (1 = two's complement), value_valid and
// value_stall; a transfer happens when valid is high and stall is low.
// Output channel: character and last with character_valid/character_stall.
// The register port sets pad_with_spaces (address 0) and target_length
// (address 4); write them only while no value is in progress.
// Sequence: the value loads at its input transfer, then 32 shift-add-3 steps
// and one measuring state run before characters go into the output register,
// one character a cycle while the receiver does not stall. A value gives 1
// to 11 characters at the default buffer size. The next value is taken while
// the last character still waits in the output register.
// A stalled receiver holds the output register and pauses emission; the
// conversion itself is not held up. Reset empties the output register,
// returns the controller to idle and clears both registers.

module integer_to_padded_decimal_text #(
  parameter int BUF_CHARS = itoa_pkg::BUF_CHARS
) (
  input  logic        clk,
  input  logic        rst,
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel.
  input  logic        value_valid,
  output logic        value_stall,
  input  logic [31:0] value,
  input  logic        command,
  // Output channel.
  output logic        character_valid,
  input  logic        character_stall,
  output logic [7:0]  character,
  output logic        last
);

  logic                              pad_with_spaces;
  logic [itoa_pkg::LEN_W-1:0]        target_length;
  logic                              wr_en;
  itoa_pkg::cmd_t                    cmd;
  itoa_pkg::status_t                 status;

  // Configuration registers.
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_with_spaces <= 1'b0;
      target_length   <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        itoa_pkg::REG_PAD:    pad_with_spaces <= pwdata[0];
        itoa_pkg::REG_TARGET: target_length   <= pwdata[itoa_pkg::LEN_W-1:0];
        default:              pad_with_spaces <= pad_with_spaces;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      itoa_pkg::REG_PAD:    prdata = {31'b0, pad_with_spaces};
      itoa_pkg::REG_TARGET: prdata = {{(32-itoa_pkg::LEN_W){1'b0}}, target_length};
      default:              prdata = '0;
    endcase
  end

  itoa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .status      (status),
    .cmd         (cmd)
  );

  itoa_dp #(
    .BUF_CHARS (BUF_CHARS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .value           (value),
    .command         (command),
    .pad_with_spaces (pad_with_spaces),
    .target_length   (target_length),
    .cmd             (cmd),
    .status          (status),
    .character_valid (character_valid),
    .character_stall (character_stall),
    .character       (character),
    .last            (last)
  );

endmodule
